FILE: rtl/tsd_pkg.sv
// Shared constants and types for the tar stream deframer.
package tsd_pkg;

   localparam int unsigned BLOCK_BYTES = 512;
   localparam int unsigned OFF_BITS    = $clog2(BLOCK_BYTES);
   localparam int unsigned SIZE_BITS   = 36;

   localparam logic [OFF_BITS-1:0] NAME_LEN   = OFF_BITS'(100);
   localparam logic [OFF_BITS-1:0] SIZE_FIRST = OFF_BITS'(124);
   localparam logic [OFF_BITS-1:0] SIZE_LAST  = OFF_BITS'(135);
   localparam logic [OFF_BITS-1:0] OFF_LAST   = OFF_BITS'(BLOCK_BYTES - 1);

   typedef enum logic [1:0] {
      KIND_NAME   = 2'd0,
      KIND_HEADER = 2'd1,
      KIND_DATA   = 2'd2,
      KIND_END    = 2'd3
   } kind_type;

   typedef struct packed {
      kind_type             kind;
      logic [7:0]           value;
      logic [SIZE_BITS-1:0] entry_size;
      logic                 last;
   } rsp_type;

endpackage

FILE: rtl/tsd_front.sv
// Byte classifier: tracks block position, name, size field and data/padding phases.
module tsd_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             byte_valid,
   input  logic [7:0]       byte_data,
   output logic             rsp_valid,
   output tsd_pkg::rsp_type rsp_data
);

   typedef enum logic [1:0] {
      PH_HEADER = 2'd0,
      PH_DATA   = 2'd1,
      PH_PAD    = 2'd2,
      PH_END    = 2'd3
   } phase_type;

   typedef enum logic [1:0] {
      SP_SKIP   = 2'd0,
      SP_DIGITS = 2'd1,
      SP_DONE   = 2'd2
   } parse_type;

   localparam logic [tsd_pkg::SIZE_BITS-1:0] SIZE_MAX  = '1;
   localparam logic [tsd_pkg::SIZE_BITS-1:0] SHIFT_LIM = SIZE_MAX >> 3;

   phase_type                       phase_ff, phase_in;
   parse_type                       parse_ff, parse_in;
   logic [tsd_pkg::OFF_BITS-1:0]    offset_ff, offset_in;
   logic [tsd_pkg::SIZE_BITS-1:0]   accum_ff, accum_in;
   logic [tsd_pkg::SIZE_BITS-1:0]   left_ff, left_in;
   logic                            name_end_ff, name_end_in;

   logic [tsd_pkg::OFF_BITS-1:0]    offset_next;
   logic                            is_digit;
   logic [tsd_pkg::SIZE_BITS+2:0]   shifted;
   logic [tsd_pkg::SIZE_BITS-1:0]   left_dec;

   assign offset_next = offset_ff + (tsd_pkg::OFF_BITS)'(1);
   assign is_digit    = (byte_data >= 8'h30) && (byte_data <= 8'h37);
   assign shifted     = {accum_ff, 3'b000} + (tsd_pkg::SIZE_BITS+3)'(byte_data[2:0]);
   assign left_dec    = (left_ff == '0) ? '0 : left_ff - (tsd_pkg::SIZE_BITS)'(1);

   always_comb begin
      phase_in    = phase_ff;
      parse_in    = parse_ff;
      offset_in   = offset_ff;
      accum_in    = accum_ff;
      left_in     = left_ff;
      name_end_in = name_end_ff;
      rsp_valid   = 1'b0;
      rsp_data    = '{kind: tsd_pkg::KIND_NAME, value: '0, entry_size: '0, last: 1'b0};
      if (byte_valid) begin
         unique case (phase_ff)
            PH_HEADER: begin
               if (offset_ff == '0 && byte_data == 8'h00) begin
                  phase_in       = PH_END;
                  rsp_valid      = 1'b1;
                  rsp_data.kind  = tsd_pkg::KIND_END;
               end else begin
                  offset_in = offset_next;
                  if (offset_ff < tsd_pkg::NAME_LEN && !name_end_ff) begin
                     if (byte_data == 8'h00) begin
                        name_end_in = 1'b1;
                     end else begin
                        rsp_valid      = 1'b1;
                        rsp_data.value = byte_data;
                     end
                  end
                  if (offset_ff >= tsd_pkg::SIZE_FIRST && offset_ff <= tsd_pkg::SIZE_LAST &&
                      parse_ff != SP_DONE &&
                      !(parse_ff == SP_SKIP && byte_data == 8'h20)) begin
                     if (!is_digit) begin
                        parse_in = SP_DONE;
                     end else begin
                        parse_in = SP_DIGITS;
                        if (accum_ff > SHIFT_LIM ||
                            shifted > (tsd_pkg::SIZE_BITS+3)'(SIZE_MAX)) begin
                           accum_in = SIZE_MAX;
                        end else begin
                           accum_in = shifted[tsd_pkg::SIZE_BITS-1:0];
                        end
                     end
                  end
                  if (offset_ff == tsd_pkg::OFF_LAST) begin
                     rsp_valid           = 1'b1;
                     rsp_data.kind       = tsd_pkg::KIND_HEADER;
                     rsp_data.value      = '0;
                     rsp_data.entry_size = accum_ff;
                     rsp_data.last       = (accum_ff == '0);
                     left_in             = accum_ff;
                     phase_in            = (accum_ff == '0) ? PH_HEADER : PH_DATA;
                     accum_in            = '0;
                     parse_in            = SP_SKIP;
                     name_end_in         = 1'b0;
                  end
               end
            end
            PH_DATA: begin
               offset_in      = offset_next;
               left_in        = left_dec;
               rsp_valid      = 1'b1;
               rsp_data.kind  = tsd_pkg::KIND_DATA;
               rsp_data.value = byte_data;
               rsp_data.last  = (left_dec == '0);
               if (left_dec == '0) begin
                  phase_in = (offset_next == '0) ? PH_HEADER : PH_PAD;
               end
            end
            PH_PAD: begin
               offset_in = offset_next;
               if (offset_next == '0) begin
                  phase_in = PH_HEADER;
               end
            end
            PH_END: begin
               // drop every byte after archive end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_HEADER;
         parse_ff    <= SP_SKIP;
         offset_ff   <= '0;
         accum_ff    <= '0;
         left_ff     <= '0;
         name_end_ff <= 1'b0;
      end else begin
         phase_ff    <= phase_in;
         parse_ff    <= parse_in;
         offset_ff   <= offset_in;
         accum_ff    <= accum_in;
         left_ff     <= left_in;
         name_end_ff <= name_end_in;
      end
   end

endmodule

FILE: rtl/tsd_queue.sv
// Four-entry result queue between the classifier and the result port.
module tsd_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             wr_en,
   input  tsd_pkg::rsp_type wr_data,
   input  logic             rd_en,
   output tsd_pkg::rsp_type rd_data,
   output logic             full,
   output logic             empty
);

   tsd_pkg::rsp_type entry_ff [4];
   logic [1:0]       wr_ptr_ff, wr_ptr_in;
   logic [1:0]       rd_ptr_ff, rd_ptr_in;
   logic [2:0]       count_ff, count_in;
   logic             do_wr, do_rd;

   assign full    = (count_ff == 3'd4);
   assign empty   = (count_ff == 3'd0);
   assign do_wr   = wr_en && !full;
   assign do_rd   = rd_en && !empty;
   assign rd_data = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff + 2'(do_wr);
      rd_ptr_in = rd_ptr_ff + 2'(do_rd);
      count_in  = count_ff + 3'(do_wr) - 3'(do_rd);
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         entry_ff[wr_ptr_ff] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

FILE: rtl/tar_stream_deframer.sv
// Top level of the tar stream deframer: byte classifier plus result queue.
//
// Usage: drive one archive byte per transaction on req_archive_byte with push;
// a transaction completes at a clock edge where push is high and full is low.
// Results leave as a queue: while empty is low the oldest result sits on
// rsp_kind / rsp_value / rsp_entry_size / rsp_last, and pop takes it.
// Kinds: name byte, header complete (with the octal file size), file data
// byte (last marks the final byte of a file) and archive end.
// Throughput: one byte per cycle while full is low. The classifier updates its block offset,
// octal accumulator and byte count in the same cycle it takes a byte.
// A result caused by a byte enters the queue at the edge that completes the
// transaction carrying it, so empty is low in the following cycle.
// Stall: results collect in a four-entry queue; full rises only when that
// queue holds four results, so the sender stalls only while the receiver
// has left four results untaken. Bytes that cause no result still need a
// free queue slot to be accepted.
// Reset: synchronous, active high; it empties the queue and returns the
// parser to the start of a header block.
module tar_stream_deframer (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push,
   output logic                          full,
   input  logic [7:0]                    req_archive_byte,
   output logic                          empty,
   input  logic                          pop,
   output logic [1:0]                    rsp_kind,
   output logic [7:0]                    rsp_value,
   output logic [tsd_pkg::SIZE_BITS-1:0] rsp_entry_size,
   output logic                          rsp_last
);

   logic             accept;
   logic             res_valid;
   tsd_pkg::rsp_type res_data;
   tsd_pkg::rsp_type head;

   // advance the parser only on a completed input transaction
   assign accept = push && !full;

   tsd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .byte_valid (accept),
      .byte_data  (req_archive_byte),
      .rsp_valid  (res_valid),
      .rsp_data   (res_data)
   );

   // hold results here until the receiver pops them
   tsd_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (res_valid),
      .wr_data (res_data),
      .rd_en   (pop),
      .rd_data (head),
      .full    (full),
      .empty   (empty)
   );

   assign rsp_kind       = head.kind;
   assign rsp_value      = head.value;
   assign rsp_entry_size = head.entry_size;
   assign rsp_last       = head.last;

endmodule

FILE: tb/tb.sv
// Self-checking testbench for the tar stream deframer: directed and random ustar streams.
`timescale 1ns / 100ps

module tb;

   localparam int          SIZE_W       = tsd_pkg::SIZE_BITS;
   localparam int          STALL_LIMIT  = 400;
   localparam int          REPORT_LIMIT = 200;
   localparam logic [SIZE_W-1:0] SIZE_MAX = '1;

   // Characters that matter in the size field
   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_SEVEN = 8'h37;
   localparam logic [7:0] CH_EIGHT = 8'h38;
   localparam logic [7:0] CH_LOWZ  = 8'h7A;

   typedef enum logic [1:0] {ST_HEADER, ST_DATA, ST_PAD, ST_ENDED} arc_phase_type;
   typedef enum logic [1:0] {SP_SKIP, SP_DIGITS, SP_DONE} size_scan_type;
   typedef enum int {
      SF_STD, SF_SPACED, SF_FULL, SF_BLANK, SF_SIGNED, SF_BADDIGIT, SF_JUNK
   } size_form_type;

   logic                 clock;
   logic                 reset;
   logic                 push;
   logic                 full;
   logic [7:0]           req_archive_byte;
   logic                 empty;
   logic                 pop;
   logic [1:0]           rsp_kind;
   logic [7:0]           rsp_value;
   logic [SIZE_W-1:0]    rsp_entry_size;
   logic                 rsp_last;

   // Shadow of the parser state, advanced once per accepted byte
   arc_phase_type        arc_phase  = ST_HEADER;
   logic [8:0]           blk_off    = '0;
   logic [SIZE_W-1:0]    size_acc   = '0;
   size_scan_type        size_state = SP_SKIP;
   logic                 name_done  = 1'b0;
   logic [SIZE_W-1:0]    data_left  = '0;

   tsd_pkg::rsp_type     due_results[$];
   tsd_pkg::rsp_type     want;
   logic [7:0]           hdr[512];
   int                   mismatches  = 0;
   int                   idle_cycles = 0;
   int                   pop_hold    = 0;
   bit                   idle_on     = 1'b1;

   tar_stream_deframer u_dut (
      .clock            (clock),
      .reset            (reset),
      .push             (push),
      .full             (full),
      .req_archive_byte (req_archive_byte),
      .empty            (empty),
      .pop              (pop),
      .rsp_kind         (rsp_kind),
      .rsp_value        (rsp_value),
      .rsp_entry_size   (rsp_entry_size),
      .rsp_last         (rsp_last)
   );

   always begin
      clock = 1'b1;
      #6;
      clock = 1'b0;
      #6;
   end

   function automatic void queue_result(input tsd_pkg::kind_type k, input logic [7:0] v,
                                        input logic [SIZE_W-1:0] sz, input logic lst);
      tsd_pkg::rsp_type r;
      r.kind       = k;
      r.value      = v;
      r.entry_size = sz;
      r.last       = lst;
      due_results.push_back(r);
   endfunction

   // Advance the shadow parser by one archive byte and queue what it emits.
   function automatic void track_byte(input logic [7:0] b);
      logic [SIZE_W+2:0] shifted;
      logic [SIZE_W-1:0] left;
      if (arc_phase == ST_ENDED) return;
      if (arc_phase == ST_HEADER) begin
         // A zero first byte is the end-of-archive marker
         if (blk_off == '0 && b == CH_NUL) begin
            arc_phase = ST_ENDED;
            queue_result(tsd_pkg::KIND_END, 8'h00, '0, 1'b0);
            return;
         end
         // Emit name bytes until the first NUL
         if (blk_off < tsd_pkg::NAME_LEN && !name_done) begin
            if (b == CH_NUL) name_done = 1'b1;
            else queue_result(tsd_pkg::KIND_NAME, b, '0, 1'b0);
         end
         // Octal size: skip leading spaces, stop on any non-octal character
         if (blk_off >= tsd_pkg::SIZE_FIRST && blk_off <= tsd_pkg::SIZE_LAST &&
             size_state != SP_DONE) begin
            if (size_state == SP_SKIP && b == CH_SPACE) begin
               // leading space, keep skipping
            end else if (b < CH_ZERO || b > CH_SEVEN) begin
               size_state = SP_DONE;
            end else begin
               size_state = SP_DIGITS;
               if (size_acc > (SIZE_MAX >> 3)) begin
                  size_acc = SIZE_MAX;
               end else begin
                  shifted  = {size_acc, 3'b000} + (b - CH_ZERO);
                  size_acc = (shifted > SIZE_MAX) ? SIZE_MAX : shifted[SIZE_W-1:0];
               end
            end
         end
         if (blk_off == tsd_pkg::OFF_LAST) begin
            queue_result(tsd_pkg::KIND_HEADER, 8'h00, size_acc, size_acc == '0);
            data_left  = size_acc;
            arc_phase  = (size_acc == '0) ? ST_HEADER : ST_DATA;
            size_acc   = '0;
            size_state = SP_SKIP;
            name_done  = 1'b0;
            blk_off    = '0;
            return;
         end
         blk_off = blk_off + 9'd1;
         return;
      end
      if (arc_phase == ST_DATA) begin
         left      = (data_left == '0) ? '0 : data_left - SIZE_W'(1);
         data_left = left;
         queue_result(tsd_pkg::KIND_DATA, b, '0, left == '0);
         blk_off = blk_off + 9'd1;
         if (left == '0) arc_phase = (blk_off == '0) ? ST_HEADER : ST_PAD;
         return;
      end
      // Padding: drop bytes up to the block boundary
      blk_off = blk_off + 9'd1;
      if (blk_off == '0) arc_phase = ST_HEADER;
   endfunction

   // Drive one byte from a falling edge, hold it until the transaction completes.
   task automatic send_byte(input logic [7:0] b);
      if (idle_on && $urandom_range(0, 24) == 0) repeat ($urandom_range(1, 19)) @(negedge clock);
      push             = 1'b1;
      req_archive_byte = b;
      @(posedge clock);
      while (full) @(posedge clock);
      track_byte(b);
      @(negedge clock);
      push = 1'b0;
   endtask

   // Hold the sender until every queued result has been taken.
   task automatic wait_drained();
      while (due_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      @(negedge clock);
   endtask

   function automatic int octal_len(input logic [SIZE_W-1:0] v);
      int n;
      n = 1;
      while (n < 12 && (v >> (3 * n)) != '0) n++;
      return n;
   endfunction

   function automatic void put_octal(input int start, input int ndig,
                                     input logic [SIZE_W-1:0] v);
      for (int k = 0; k < ndig; k++)
         hdr[start + k] = CH_ZERO | 8'((v >> (3 * (ndig - 1 - k))) & 'h7);
   endfunction

   // Fill a header block: random filler, a name of the given length, and a size field.
   task automatic build_header(input int name_len, input size_form_type form,
                               input logic [SIZE_W-1:0] size_val);
      int pos;
      int nd;
      for (int i = 0; i < 512; i++) hdr[i] = 8'($urandom_range(0, 255));
      for (int i = 0; i < name_len; i++) hdr[i] = 8'($urandom_range(1, 255));
      if (name_len < 100) hdr[name_len] = CH_NUL;
      nd  = octal_len(size_val);
      pos = 124;
      case (form)
         SF_STD: begin
            put_octal(124, 11, size_val);
            hdr[135] = CH_NUL;
         end
         SF_FULL: put_octal(124, 12, size_val);
         SF_SPACED: begin
            repeat ($urandom_range(1, 4)) begin
               hdr[pos] = CH_SPACE;
               pos++;
            end
            put_octal(pos, nd, size_val);
            pos += nd;
            if (pos <= 135) hdr[pos] = $urandom_range(0, 1) ? CH_SPACE : CH_NUL;
         end
         SF_BLANK: for (int i = 124; i <= 135; i++) hdr[i] = CH_SPACE;
         SF_SIGNED: begin
            if ($urandom_range(0, 1)) begin
               hdr[pos] = CH_SPACE;
               pos++;
            end
            hdr[pos] = $urandom_range(0, 1) ? CH_PLUS : CH_MINUS;
            put_octal(pos + 1, nd, size_val);
         end
         SF_BADDIGIT: begin
            put_octal(124, nd, size_val);
            hdr[124 + nd] = CH_EIGHT + 8'($urandom_range(0, 1));
            for (int i = 125 + nd; i <= 135; i++) hdr[i] = CH_ZERO + 8'($urandom_range(0, 7));
         end
         default: begin
            // random field; a letter mid-field keeps any digit run short
            hdr[128] = CH_LOWZ;
         end
      endcase
   endtask

   task automatic send_header();
      for (int i = 0; i < 512; i++) send_byte(hdr[i]);
   endtask

   // Send file data and padding until the parser expects the next header.
   task automatic send_body();
      int n;
      n = 0;
      while (arc_phase == ST_DATA || arc_phase == ST_PAD) begin
         send_byte(n == 0 ? 8'h00 : n == 1 ? 8'hFF : 8'($urandom_range(0, 255)));
         n++;
      end
   endtask

   // Full 100-byte name with no NUL; a signed size field parses as zero, so the
   // header closes an empty file
   task automatic test_name_forms();
      build_header(100, SF_SIGNED, 7);
      hdr[0] = 8'hFF;
      send_header();
      send_body();
   endtask

   // Size field in one of the digit forms, giving a file that fills one data block
   // exactly; idling stops for the rest of the run once the header is in
   task automatic test_size_parsing();
      int pick;
      size_form_type form;
      pick = $urandom_range(0, 2);
      if (pick == 0) form = SF_STD;
      else if (pick == 1) form = SF_SPACED;
      else form = SF_FULL;
      build_header($urandom_range(1, 99), form, SIZE_W'(512));
      send_header();
      idle_on = 1'b0;
      send_body();
   endtask

   // End marker, then trailing bytes that must produce nothing
   task automatic test_archive_end();
      send_byte(8'h00);
      send_byte(8'hFF);
      send_byte(8'h00);
      repeat (20) send_byte(8'($urandom_range(0, 255)));
   endtask

   // Receiver: take results, stalling in random bursts while idling is on.
   always @(negedge clock) begin
      if (!idle_on) begin
         pop = 1'b1;
      end else if (pop_hold > 0) begin
         pop_hold--;
         pop = 1'b0;
      end else if ($urandom_range(0, 15) == 0) begin
         pop_hold = $urandom_range(0, 18);
         pop      = 1'b0;
      end else begin
         pop = 1'b1;
      end
   end

   function automatic void check_field(input string field, input logic [SIZE_W-1:0] expv,
                                       input logic [SIZE_W-1:0] got);
      if (got !== expv) begin
         mismatches++;
         if (mismatches <= REPORT_LIMIT)
            $display("%0t: %s expected %0h got %0h", $time, field, expv, got);
      end
   endfunction

   // Compare every completed result transaction with the oldest expectation.
   always @(posedge clock) begin
      if (!reset && pop && !empty) begin
         if (due_results.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display("%0t: result expected none got kind %0d value %0h size %0h last %0b",
                        $time, rsp_kind, rsp_value, rsp_entry_size, rsp_last);
         end else begin
            want = due_results.pop_front();
            check_field("kind", SIZE_W'(want.kind), SIZE_W'(rsp_kind));
            check_field("value", SIZE_W'(want.value), SIZE_W'(rsp_value));
            check_field("entry_size", want.entry_size, rsp_entry_size);
            check_field("last", SIZE_W'(want.last), SIZE_W'(rsp_last));
         end
      end
   end

   // Watchdog: end the run if no transaction completes on either side for too long.
   always @(posedge clock) begin
      if (reset || (push && !full) || (pop && !empty)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   initial begin
      reset            = 1'b1;
      push             = 1'b0;
      pop              = 1'b0;
      req_archive_byte = 8'h00;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_name_forms();
      wait_drained();
      test_size_parsing();
      wait_drained();
      test_archive_end();

      // Drain, then give stray results time to show up
      while (due_results.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (mismatches == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

FILE: sim.f
rtl/tsd_pkg.sv
rtl/tsd_front.sv
rtl/tsd_queue.sv
rtl/tar_stream_deframer.sv
tb/tb.sv
